// ===== rtl/bitmap_page_allocator_core_assert.svh =====
// Assertion macros used by the page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("page allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("page allocator assertion failed");

`endif

// ===== rtl/bpa_pkg.sv =====
// Types and constants of the bitmap page allocator.
`default_nettype none
package bpa_pkg;

  localparam int unsigned NUM_PAGES = 4096;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned CFG_W = 13;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] page_index;
    logic [CNT_W-1:0] page_cnt;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] start_page;
    logic [CNT_W-1:0] used_total;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/bpa_page_map.sv =====
// One-bit-per-page used map, single port, registered read data.
`default_nettype none
module bpa_page_map #(
  parameter int unsigned NUM_PAGES = 4096,
  parameter int unsigned AW        = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic          wdata_i,
  output logic               rdata_o
);

  logic mem [NUM_PAGES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/bitmap_page_allocator_core.sv =====
// Bitmap first-fit page allocator: control sequencer around the used map.
// Allocate scans a page per cycle, up to the page limit.
// A zero-count allocate fails without scanning.
// One command at a time; busy stays high until the result strobe.
// After reset a sweep marks every page used (busy high).
// Results appear on done_o for exactly one cycle; they cannot be stalled.
`default_nettype none
module bitmap_page_allocator_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bpa_pkg::req_t             req_i,
  output logic                           done_o,
  output bpa_pkg::res_t                  res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bpa_pkg::CFG_W-1:0] cfg_wdata_i
);
  import bpa_pkg::*;

  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned LW = (CW > CNT_W) ? CW : CNT_W;

  state_e state_q, state_d;
  logic [CFG_W-1:0] limit_cfg_q;
  logic [CW-1:0]    used_q, used_d;
  logic [LW-1:0]    iss_q, iss_d, evp_q, evp_d;
  logic             vld_q, vld_d;
  logic [CNT_W-1:0] run_len_q, run_len_d, want_q, want_d, rem_q, rem_d;
  logic [LW-1:0]    run_start_q, run_start_d;
  logic [LW-1:0]    wp_q, wp_d;
  logic             wval_q, wval_d;
  logic             ok_q, ok_d;
  logic [IDX_W-1:0] sp_q, sp_d;

  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_addr;
  logic [LW-1:0] limit, cfg_ext, used_ext;
  logic [LW:0]   sum;
  logic [CNT_W-1:0] nl;

  assign cfg_ext  = LW'(limit_cfg_q);
  assign limit    = (cfg_ext > LW'(NUM_PAGES)) ? LW'(NUM_PAGES) : cfg_ext;
  assign used_ext = LW'(used_q);
  assign sum      = (LW + 1)'(used_ext) + (LW + 1)'(want_q);
  assign nl       = run_len_q + CNT_W'(1);

  bpa_page_map #(.NUM_PAGES(NUM_PAGES), .AW(AW)) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      limit_cfg_q <= CFG_W'(4096);
      used_q      <= CW'(NUM_PAGES);
      vld_q       <= 1'b0;
      wp_q        <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      vld_q   <= vld_d;
      wp_q    <= wp_d;
      if (cfg_we_i) begin
        limit_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q       <= iss_d;
    evp_q       <= evp_d;
    run_len_q   <= run_len_d;
    run_start_q <= run_start_d;
    want_q      <= want_d;
    rem_q       <= rem_d;
    wval_q      <= wval_d;
    ok_q        <= ok_d;
    sp_q        <= sp_d;
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    iss_d       = iss_q;
    evp_d       = evp_q;
    vld_d       = 1'b0;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    want_d      = want_q;
    rem_d       = rem_q;
    wp_d        = wp_q;
    wval_d      = wval_q;
    ok_d        = ok_q;
    sp_d        = sp_q;
    mem_we      = 1'b0;
    mem_wdata   = wval_q;
    mem_addr    = wp_q[AW-1:0];
    busy        = (state_q != ST_IDLE);
    done_o      = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        wp_d      = wp_q + LW'(1);
        if (wp_q == LW'(NUM_PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ok_d   = 1'b0;
          sp_d   = '0;
          want_d = req_i.page_cnt;
          case (req_i.cmd)
            CMD_ALLOC: begin
              iss_d       = '0;
              run_len_d   = '0;
              run_start_d = '0;
              state_d     = (req_i.page_cnt == '0) ? ST_DONE : ST_SCAN;
            end
            CMD_FREE: begin
              ok_d    = 1'b1;
              wp_d    = LW'(req_i.page_index);
              rem_d   = req_i.page_cnt;
              wval_d  = 1'b0;
              used_d  = (used_ext > LW'(req_i.page_cnt)) ?
                        CW'(used_ext - LW'(req_i.page_cnt)) : '0;
              state_d = ST_FILL;
            end
            CMD_MARK: begin
              ok_d    = 1'b1;
              wp_d    = LW'(req_i.page_index);
              rem_d   = CNT_W'(1);
              wval_d  = 1'b1;
              state_d = ST_FILL;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_addr = iss_q[AW-1:0];
        if (vld_q && !mem_rdata && (nl == want_q)) begin
          // The run is complete; a run at page 0 is reported as failure.
          if (run_start_q == '0) begin
            state_d = ST_DONE;
          end else begin
            ok_d    = 1'b1;
            sp_d    = run_start_q[IDX_W-1:0];
            wp_d    = run_start_q;
            rem_d   = want_q;
            wval_d  = 1'b1;
            used_d  = (sum > (LW + 1)'(NUM_PAGES)) ? CW'(NUM_PAGES) : CW'(sum);
            state_d = ST_FILL;
          end
        end else begin
          if (vld_q) begin
            if (!mem_rdata) begin
              run_len_d = nl;
            end else begin
              run_len_d   = '0;
              run_start_d = evp_q + LW'(1);
            end
          end
          if (iss_q < limit) begin
            iss_d = iss_q + LW'(1);
            evp_d = iss_q;
            vld_d = 1'b1;
          end else if (!vld_q) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FILL: begin
        if ((rem_q == '0) || (wp_q >= LW'(NUM_PAGES))) begin
          state_d = ST_DONE;
        end else begin
          mem_we = 1'b1;
          wp_d   = wp_q + LW'(1);
          rem_d  = rem_q - CNT_W'(1);
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.ok         = ok_q;
  assign res_o.start_page = sp_q;
  assign res_o.used_total = used_ext[CNT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/bpa_checker.sv =====
// Port-level checks of the page allocator, bound to the top level.
`default_nettype none
`include "bitmap_page_allocator_core_assert.svh"
module bpa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire bpa_pkg::res_t res_o
);
  import bpa_pkg::*;

  // A result is only shown while a transaction is still in flight.
  `BPA_ASSERT_IMP(a_done_while_busy, clk_i, rst_ni, done_o, busy)
  // An accepted transaction keeps the block busy in the next cycle.
  `BPA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)
  // The strobe lasts one cycle and the block is then free again.
  `BPA_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o && !busy)
  // A failed command never reports a start page.
  `BPA_ASSERT_IMP(a_fail_no_page, clk_i, rst_ni, done_o && !res_o.ok,
                  res_o.start_page == '0)

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
`default_nettype wire
